@@ sv/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies; expects i_clk and i_rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ sv/lht_pkg.sv @@
// types, constants and helper functions for the lru handle table
// no dependencies; used by every module of the block
package lht_pkg;

    localparam int ENTRIES    = 7;
    localparam int KEY_WIDTH  = 32;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int TIME_W     = 32;
    localparam int HANDLE_W   = 16;
    localparam int IN_KEY_W   = 32;
    localparam int SLOT_W     = 3;

    typedef struct packed {
        logic [IN_KEY_W-1:0] key;
        logic [HANDLE_W-1:0] new_handle;
    } t_in;

    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic [HANDLE_W-1:0] handle;
        logic                evicted;
        logic [HANDLE_W-1:0] evicted_handle;
    } t_out;

    // search token carried along the chain of cells
    typedef struct packed {
        logic                found;
        logic [IDX_W-1:0]    found_idx;
        logic [HANDLE_W-1:0] found_handle;
        logic                free_ok;
        logic [IDX_W-1:0]    free_idx;
        logic                best_ok;
        logic [TIME_W-1:0]   best_time;
        logic [IDX_W-1:0]    best_idx;
        logic [HANDLE_W-1:0] best_handle;
    } t_scan;

    // write command broadcast to all cells
    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     idx;
        logic                 fill;
        logic [KEY_WIDTH-1:0] key;
        logic [HANDLE_W-1:0]  handle;
        logic [TIME_W-1:0]    stamp;
    } t_wr;

    function automatic logic [KEY_WIDTH-1:0] key_fit(input logic [IN_KEY_W-1:0] k);
        logic [KEY_WIDTH-1:0] r;
        for (int i = 0; i < KEY_WIDTH; i++) begin
            r[i] = (i < IN_KEY_W) ? k[i] : 1'b0;
        end
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] idx_to_slot(input logic [IDX_W-1:0] idx);
        logic [SLOT_W-1:0] r;
        for (int i = 0; i < SLOT_W; i++) begin
            r[i] = (i < IDX_W) ? idx[i] : 1'b0;
        end
        return r;
    endfunction

endpackage

@@ sv/lht_cell.sv @@
// one table entry: key, handle and time, plus one stage of the search chain
// depends on lht_pkg
module lht_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [lht_pkg::IDX_W-1:0]     i_idx,
    input  logic [lht_pkg::KEY_WIDTH-1:0] i_req_key,
    input  logic                          i_valid,
    input  lht_pkg::t_scan                i_scan,
    input  lht_pkg::t_wr                  i_wr,
    output logic                          o_valid,
    output lht_pkg::t_scan                o_scan
);

    logic [lht_pkg::KEY_WIDTH-1:0] r_key;
    logic [lht_pkg::HANDLE_W-1:0]  r_handle;
    logic [lht_pkg::TIME_W-1:0]    r_time;
    logic                          r_valid;
    lht_pkg::t_scan                r_scan;
    lht_pkg::t_scan                n_scan;
    logic                          w_sel;

    assign w_sel = i_wr.en && (i_wr.idx == i_idx);

    always_comb begin
        n_scan = i_scan;
        if (!i_scan.found && (r_key == i_req_key)) begin
            n_scan.found        = 1'b1;
            n_scan.found_idx    = i_idx;
            n_scan.found_handle = r_handle;
        end
        if ((r_key == '0) && !i_scan.free_ok) begin
            n_scan.free_ok  = 1'b1;
            n_scan.free_idx = i_idx;
        end
        if (!i_scan.best_ok || (r_time < i_scan.best_time)) begin
            n_scan.best_ok     = 1'b1;
            n_scan.best_time   = r_time;
            n_scan.best_idx    = i_idx;
            n_scan.best_handle = r_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_key   <= '0;
            r_time  <= '0;
        end else begin
            r_valid <= i_valid;
            if (w_sel) begin
                r_time <= i_wr.stamp;
                if (i_wr.fill) begin
                    r_key <= i_wr.key;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        if (w_sel && i_wr.fill) begin
            r_handle <= i_wr.handle;
        end
    end

    assign o_valid = r_valid;
    assign o_scan  = r_scan;

endmodule

@@ sv/lru_handle_table.sv @@
// lru handle table: a lookup passes the inject register, the chain of cells, the result
// register and the output register; a zero key goes from idle straight to the done state;
// a new lookup is taken only in idle; the search token walks the cells one entry per cycle
// reset clears all keys, times, the use counter and the output valid at once
// depends on lht_pkg and lht_cell
module lru_handle_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lht_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lht_pkg::t_out o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                        r_state;
    logic                          r_inject;
    logic [lht_pkg::TIME_W-1:0]    r_cnt;
    logic [lht_pkg::KEY_WIDTH-1:0] r_req_key;
    logic [lht_pkg::HANDLE_W-1:0]  r_new_handle;
    logic                          r_zero;
    lht_pkg::t_scan                r_res;
    logic                          r_out_valid;
    lht_pkg::t_out                 r_out;

    lht_pkg::t_out                 n_out;
    lht_pkg::t_wr                  w_wr;
    logic [lht_pkg::IDX_W-1:0]     w_fill_idx;
    logic [lht_pkg::KEY_WIDTH-1:0] w_key;
    logic                          w_out_free;

    logic                          w_valid [0:lht_pkg::ENTRIES];
    lht_pkg::t_scan                w_scan  [0:lht_pkg::ENTRIES];

    assign w_key      = lht_pkg::key_fit(i_in.key);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fill_idx = r_res.free_ok ? r_res.free_idx : r_res.best_idx;

    assign w_valid[0] = r_inject;
    assign w_scan[0]  = '0;

    for (genvar g = 0; g < lht_pkg::ENTRIES; g++) begin : g_cell
        lht_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_idx     (lht_pkg::IDX_W'(g)),
            .i_req_key (r_req_key),
            .i_valid   (w_valid[g]),
            .i_scan    (w_scan[g]),
            .i_wr      (w_wr),
            .o_valid   (w_valid[g+1]),
            .o_scan    (w_scan[g+1])
        );
    end

    always_comb begin
        n_out = '0;
        if (!r_zero) begin
            if (r_res.found) begin
                n_out.hit    = 1'b1;
                n_out.slot   = lht_pkg::idx_to_slot(r_res.found_idx);
                n_out.handle = r_res.found_handle;
            end else begin
                n_out.slot   = lht_pkg::idx_to_slot(w_fill_idx);
                n_out.handle = r_new_handle;
                if (!r_res.free_ok) begin
                    n_out.evicted        = 1'b1;
                    n_out.evicted_handle = r_res.best_handle;
                end
            end
        end
    end

    always_comb begin
        w_wr.en     = (r_state == S_DONE) && w_out_free && !r_zero;
        w_wr.idx    = r_res.found ? r_res.found_idx : w_fill_idx;
        w_wr.fill   = !r_res.found;
        w_wr.key    = r_req_key;
        w_wr.handle = r_new_handle;
        w_wr.stamp  = r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inject    <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_inject    <= (r_state == S_IDLE) && i_in_valid && (w_key != '0);
            r_out_valid <= ((r_state == S_DONE) && w_out_free) ||
                           (r_out_valid && i_out_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cnt        <= r_cnt + 1'b1;
                        r_req_key    <= w_key;
                        r_new_handle <= i_in.new_handle;
                        r_zero       <= (w_key == '0);
                        if (w_key == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_valid[lht_pkg::ENTRIES]) begin
                        r_res   <= w_scan[lht_pkg::ENTRIES];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out   <= n_out;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ sv/lht_checker.sv @@
// port-level checks for the lru handle table, bound to the top level
// depends on lht_pkg, assert_macros.svh and lru_handle_table
`include "assert_macros.svh"

module lht_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input lht_pkg::t_out o_out
);

    `ASSERT_CLK(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "output valid dropped while stalled")
    `ASSERT_CLK(a_out_stable, o_out_valid && i_out_stall |=> $stable(o_out), "output changed while stalled")
    `ASSERT_CLK(a_busy_after_accept, i_in_valid && !o_in_stall |=> o_in_stall, "input taken twice in a row")
    `ASSERT_CLK(a_evict_miss, o_out_valid && o_out.evicted |-> !o_out.hit, "eviction reported on a hit")
    `ASSERT_CLK(a_evict_handle, o_out_valid && !o_out.evicted |-> o_out.evicted_handle == '0, "evicted handle without eviction")

endmodule

bind lru_handle_table lht_checker u_lht_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

@@ sim/tb.sv @@
// self-checking testbench for lru_handle_table: directed and random lookups
// with bursty input, receiver stalls and a long output hold-off
// depends on lht_pkg and the lru_handle_table rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 9;
    localparam int LATENCY      = lht_pkg::ENTRIES + 3;
    localparam int HOLD_LEN     = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam int RANDOM_ITEMS = 1820;

    logic          i_clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          out_stall = 1'b0;
    lht_pkg::t_in  in_data = '0;
    logic          in_stall;
    logic          out_valid;
    lht_pkg::t_out out_data;

    logic [lht_pkg::KEY_WIDTH-1:0] tbl_key [lht_pkg::ENTRIES];
    logic [lht_pkg::HANDLE_W-1:0]  tbl_handle [lht_pkg::ENTRIES];
    logic [lht_pkg::TIME_W-1:0]    tbl_stamp [lht_pkg::ENTRIES];
    logic [lht_pkg::TIME_W-1:0]    lookup_count;

    lht_pkg::t_out pending_results [$];
    int   mismatch_count = 0;
    int   burst_left = 0;
    int   hold_requests = 0;
    int   holds_served = 0;
    int   idle_cycles = 0;

    lru_handle_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_data)
    );

    initial begin
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    function automatic lht_pkg::t_out predict_lookup(input lht_pkg::t_in req);
        lht_pkg::t_out                 r;
        logic [lht_pkg::KEY_WIDTH-1:0] k;
        logic [lht_pkg::TIME_W-1:0]    oldest;
        int                            pick;
        r = '0;
        k = req.key[lht_pkg::KEY_WIDTH-1:0];
        pick = -1;
        lookup_count = lookup_count + 1'b1;
        if (k == '0) begin
            return r;
        end
        for (int i = 0; i < lht_pkg::ENTRIES; i++) begin
            if (tbl_key[i] == k) begin
                tbl_stamp[i] = lookup_count;
                r.hit = 1'b1;
                r.slot = i[lht_pkg::SLOT_W-1:0];
                r.handle = tbl_handle[i];
                return r;
            end
            if (tbl_key[i] == '0 && pick < 0) begin
                pick = i;
            end
        end
        if (pick < 0) begin
            pick = 0;
            oldest = tbl_stamp[0];
            for (int i = 1; i < lht_pkg::ENTRIES; i++) begin
                if (tbl_stamp[i] < oldest) begin
                    oldest = tbl_stamp[i];
                    pick = i;
                end
            end
            r.evicted = 1'b1;
            r.evicted_handle = tbl_handle[pick];
        end
        tbl_key[pick] = k;
        tbl_handle[pick] = req.new_handle;
        tbl_stamp[pick] = lookup_count;
        r.slot = pick[lht_pkg::SLOT_W-1:0];
        r.handle = req.new_handle;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
            mismatch_count++;
        end
    endfunction

    // one transaction on the input side, bursts separated by random gaps
    task automatic send_lookup(input logic [lht_pkg::IN_KEY_W-1:0] key,
                               input logic [lht_pkg::HANDLE_W-1:0] handle);
        lht_pkg::t_in req;
        int           gap;
        req.key = key;
        req.new_handle = handle;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 15);
            burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 20);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= req;
        do @(posedge i_clk); while (in_stall);
        pending_results.push_back(predict_lookup(req));
        @(negedge i_clk);
    endtask

    task automatic test_zero_key;
        send_lookup('0, '1);
        send_lookup('0, 16'h1234);
    endtask

    task automatic test_fill_and_hit;
        send_lookup(32'h0000_0001, 16'h0000);
        send_lookup(32'hFFFF_FFFF, 16'hFFFF);
        send_lookup(32'h8000_0000, 16'h8000);
        send_lookup(32'h7FFF_FFFF, 16'h7FFF);
        send_lookup(32'hAAAA_AAAA, 16'hAAAA);
        send_lookup(32'h5555_5555, 16'h5555);
        send_lookup(32'h0000_0001, 16'hBEEF);
        send_lookup(32'h1234_5678, 16'h00FF);
        send_lookup(32'hFFFF_FFFF, 16'h0F0F);
        send_lookup('0, 16'hFFFF);
        send_lookup(32'h1234_5678, 16'h0000);
    endtask

    task automatic test_lru_eviction;
        send_lookup(32'h0000_00F0, 16'hFF00);
        send_lookup(32'h8000_0000, 16'h1111);
        send_lookup(32'h0000_00F1, 16'hF0F0);
        send_lookup(32'h0000_00F2, 16'h0001);
        send_lookup(32'h0000_0001, 16'h2222);
        send_lookup(32'h7FFF_FFFF, 16'h3333);
        send_lookup(32'h0000_00F0, 16'h4444);
        send_lookup(32'h0000_00F3, 16'hFFFE);
        send_lookup('0, '0);
    endtask

    task automatic test_output_hold_off;
        hold_requests++;
        burst_left = 40;
        repeat (40) begin
            send_lookup(lht_pkg::IN_KEY_W'($urandom_range(1, 12)),
                        lht_pkg::HANDLE_W'($urandom_range(0, 16'hFFFF)));
        end
    endtask

    task automatic test_random_lookups(input int count);
        logic [lht_pkg::IN_KEY_W-1:0] key_pool [16];
        int                           pool_size;
        int                           pick;
        logic [lht_pkg::IN_KEY_W-1:0] key;
        pool_size = 1;
        for (int n = 0; n < count; n++) begin
            if (n % 150 == 0) begin
                pool_size = $urandom_range(2, 16);
                foreach (key_pool[i]) begin
                    pick = $urandom_range(0, 9);
                    key_pool[i] = (pick == 0) ? 32'h1 : (pick == 1) ? 32'hFFFF_FFFF :
                                  (pick < 5) ? lht_pkg::IN_KEY_W'($urandom_range(1, 40)) :
                                  $urandom;
                    if (key_pool[i] == '0) begin
                        key_pool[i] = 32'h1;
                    end
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                key = '0;
            end else if (pick < 13) begin
                key = $urandom;
            end else begin
                key = key_pool[$urandom_range(0, pool_size - 1)];
            end
            send_lookup(key, lht_pkg::HANDLE_W'($urandom_range(0, 16'hFFFF)));
        end
    endtask

    // receiver stall pattern, with a long hold-off on request
    initial begin
        int density;
        int phase;
        density = 0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            if (holds_served < hold_requests) begin
                out_stall <= 1'b1;
                repeat (HOLD_LEN - 1) @(negedge i_clk);
                holds_served++;
            end else begin
                if (phase == 0) begin
                    density = $urandom_range(0, 3);
                end
                phase = (phase + 1) % 64;
                case (density)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 7) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= (phase % 8) < 5;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        lht_pkg::t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no lookup outstanding");
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("hit", 32'(want.hit), 32'(out_data.hit));
                check_field("slot", 32'(want.slot), 32'(out_data.slot));
                check_field("handle", 32'(want.handle), 32'(out_data.handle));
                check_field("evicted", 32'(want.evicted), 32'(out_data.evicted));
                check_field("evicted_handle", 32'(want.evicted_handle),
                            32'(out_data.evicted_handle));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < lht_pkg::ENTRIES; i++) begin
            tbl_key[i] = '0;
            tbl_handle[i] = '0;
            tbl_stamp[i] = '0;
        end
        lookup_count = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        test_zero_key();
        test_fill_and_hit();
        test_lru_eviction();
        test_output_hold_off();
        test_random_lookups(RANDOM_ITEMS);

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
